>>> sv/taramp_pkg.sv
`default_nettype none

package taramp_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int FRAME_BITS = 16;

    // lane datapath widths
    localparam int MAG_BITS  = ANGLE_BITS + 1;
    localparam int PROD_BITS = MAG_BITS + FRAME_BITS;
    localparam int STEP_BITS = $clog2(PROD_BITS + 1);

    // configuration port
    localparam int NUM_REGS   = 6;
    localparam int ADDR_BITS  = $clog2(4 * NUM_REGS);
    localparam int INDEX_BITS = ADDR_BITS - 2;
    localparam int DATA_BITS  = 32;

    localparam logic [INDEX_BITS-1:0] REG_JOINT_PRESENT = INDEX_BITS'(0);
    localparam logic [INDEX_BITS-1:0] REG_LIMITS_VALID  = INDEX_BITS'(1);
    localparam logic [INDEX_BITS-1:0] REG_X_MIN         = INDEX_BITS'(2);
    localparam logic [INDEX_BITS-1:0] REG_X_MAX         = INDEX_BITS'(3);
    localparam logic [INDEX_BITS-1:0] REG_Y_MIN         = INDEX_BITS'(4);
    localparam logic [INDEX_BITS-1:0] REG_Y_MAX         = INDEX_BITS'(5);

    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_SET   = 2'd1;
    localparam logic [1:0] FUNC_RESET = 2'd2;
    localparam logic [1:0] FUNC_UNDEF = 2'd3;

    typedef logic signed [ANGLE_BITS-1:0] t_angle;
    typedef logic [FRAME_BITS-1:0]        t_frame;

    typedef struct packed {
        logic [1:0] func;
        t_angle     angle_x_in;
        t_angle     angle_y_in;
        t_frame     ramp_frames;
    } t_in;

    typedef struct packed {
        t_angle angle_x_now;
        t_angle angle_y_now;
        logic   finished;
        logic   changed;
        logic   rotate;
    } t_out;

    // sequencer to merge stage
    typedef struct packed {
        logic   zero_angles;
        logic   rot_en;
        t_frame count;
        t_frame total;
    } t_mrg_ctl;

endpackage

`default_nettype wire

>>> sv/two_axis_angle_ramp.sv
// channel   direction   handshake                  payload
// in        input       i_in_valid / o_in_stall    i_in  (taramp_pkg::t_in)
// out       output      o_out_valid / i_out_stall  o_out (taramp_pkg::t_out)
// cfg       input       psel / penable / pready    paddr, pwdata, prdata
//
// items are handled one at a time: accept, launch, a multiply and a restoring
// divide in each of the two axis lanes, then a finish, a handoff and a load
// reset is synchronous; ramp start, goal, count and total clear to zero, limits go to full range
// the in side stalls from the transfer until its result is loaded into the output
// register; a stalled out channel holds the next item off at that load

`default_nettype none

module two_axis_angle_ramp (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire taramp_pkg::t_in                    i_in,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output taramp_pkg::t_out                        o_out,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [taramp_pkg::ADDR_BITS-1:0]   paddr,
    input  wire logic [taramp_pkg::DATA_BITS-1:0]   pwdata,
    output logic [taramp_pkg::DATA_BITS-1:0]        prdata,
    output logic                                    pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_WAIT,
        ST_DELIVER
    } t_state;

    t_state              r_state;

    logic                r_joint;
    logic                r_limits;
    taramp_pkg::t_angle  r_x_min;
    taramp_pkg::t_angle  r_x_max;
    taramp_pkg::t_angle  r_y_min;
    taramp_pkg::t_angle  r_y_max;

    taramp_pkg::t_angle  r_start_x;
    taramp_pkg::t_angle  r_start_y;
    taramp_pkg::t_angle  r_goal_x;
    taramp_pkg::t_angle  r_goal_y;
    taramp_pkg::t_frame  r_count;
    taramp_pkg::t_frame  r_total;

    logic [1:0]          r_func;
    taramp_pkg::t_angle  r_new_x;
    taramp_pkg::t_angle  r_new_y;
    taramp_pkg::t_frame  r_new_total;

    logic                in_xfer;
    logic                cfg_wr;
    logic [taramp_pkg::INDEX_BITS-1:0] cfg_idx;
    logic                is_cmd;
    taramp_pkg::t_angle  clamp_x;
    taramp_pkg::t_angle  clamp_y;
    logic [taramp_pkg::FRAME_BITS:0]   count_inc;
    logic                lane_go;
    logic                x_done;
    logic                y_done;
    taramp_pkg::t_angle  x_angle;
    taramp_pkg::t_angle  y_angle;
    logic                mrg_ready;
    logic                mrg_load;
    taramp_pkg::t_mrg_ctl mrg_ctl;

    assign in_xfer    = i_in_valid && !o_in_stall;
    assign o_in_stall = r_state != ST_IDLE;
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign cfg_idx    = paddr[taramp_pkg::ADDR_BITS-1:2];
    assign pready     = 1'b1;

    always_comb begin
        clamp_x = i_in.angle_x_in;
        clamp_y = i_in.angle_y_in;
        if (r_limits) begin
            if (clamp_x < r_x_min) clamp_x = r_x_min;
            if (clamp_x > r_x_max) clamp_x = r_x_max;
            if (clamp_y < r_y_min) clamp_y = r_y_min;
            if (clamp_y > r_y_max) clamp_y = r_y_max;
        end
    end

    assign count_inc = {1'b0, r_count} + (taramp_pkg::FRAME_BITS + 1)'(1);
    assign is_cmd    = (r_func == taramp_pkg::FUNC_SET) || (r_func == taramp_pkg::FUNC_RESET);

    always_comb begin
        case (cfg_idx)
            taramp_pkg::REG_JOINT_PRESENT: prdata = taramp_pkg::DATA_BITS'(r_joint);
            taramp_pkg::REG_LIMITS_VALID:  prdata = taramp_pkg::DATA_BITS'(r_limits);
            taramp_pkg::REG_X_MIN:         prdata = taramp_pkg::DATA_BITS'(r_x_min);
            taramp_pkg::REG_X_MAX:         prdata = taramp_pkg::DATA_BITS'(r_x_max);
            taramp_pkg::REG_Y_MIN:         prdata = taramp_pkg::DATA_BITS'(r_y_min);
            taramp_pkg::REG_Y_MAX:         prdata = taramp_pkg::DATA_BITS'(r_y_max);
            default:                       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_joint  <= 1'b0;
            r_limits <= 1'b0;
            r_x_min  <= {1'b1, {(taramp_pkg::ANGLE_BITS-1){1'b0}}};
            r_x_max  <= {1'b0, {(taramp_pkg::ANGLE_BITS-1){1'b1}}};
            r_y_min  <= {1'b1, {(taramp_pkg::ANGLE_BITS-1){1'b0}}};
            r_y_max  <= {1'b0, {(taramp_pkg::ANGLE_BITS-1){1'b1}}};
        end else if (cfg_wr) begin
            case (cfg_idx)
                taramp_pkg::REG_JOINT_PRESENT: r_joint  <= pwdata[0];
                taramp_pkg::REG_LIMITS_VALID:  r_limits <= pwdata[0];
                taramp_pkg::REG_X_MIN: r_x_min <= pwdata[taramp_pkg::ANGLE_BITS-1:0];
                taramp_pkg::REG_X_MAX: r_x_max <= pwdata[taramp_pkg::ANGLE_BITS-1:0];
                taramp_pkg::REG_Y_MIN: r_y_min <= pwdata[taramp_pkg::ANGLE_BITS-1:0];
                taramp_pkg::REG_Y_MAX: r_y_max <= pwdata[taramp_pkg::ANGLE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_start_x <= '0;
            r_start_y <= '0;
            r_goal_x  <= '0;
            r_goal_y  <= '0;
            r_count   <= '0;
            r_total   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_func      <= i_in.func;
                        r_new_total <= i_in.ramp_frames;
                        if (i_in.func == taramp_pkg::FUNC_SET) begin
                            r_new_x <= clamp_x;
                            r_new_y <= clamp_y;
                        end else begin
                            r_new_x <= '0;
                            r_new_y <= '0;
                        end
                        if (i_in.func == taramp_pkg::FUNC_TICK && r_joint) begin
                            r_count <= (count_inc >= {1'b0, r_total})
                                     ? r_total : count_inc[taramp_pkg::FRAME_BITS-1:0];
                        end
                        r_state <= ST_LAUNCH;
                    end
                end
                ST_LAUNCH: begin
                    r_state <= ST_WAIT;
                end
                ST_WAIT: begin
                    if (x_done && y_done) begin
                        if (is_cmd) begin
                            r_start_x <= x_angle;
                            r_start_y <= y_angle;
                            r_goal_x  <= r_new_x;
                            r_goal_y  <= r_new_y;
                            r_count   <= '0;
                            r_total   <= r_new_total;
                        end
                        r_state <= ST_DELIVER;
                    end
                end
                ST_DELIVER: begin
                    if (mrg_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign lane_go  = r_state == ST_LAUNCH;
    assign mrg_load = (r_state == ST_DELIVER) && mrg_ready;

    always_comb begin
        mrg_ctl.zero_angles = is_cmd && (r_total == '0);
        mrg_ctl.rot_en      = (r_func == taramp_pkg::FUNC_TICK) && r_joint;
        mrg_ctl.count       = r_count;
        mrg_ctl.total       = r_total;
    end

    taramp_lane u_lane_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (lane_go),
        .i_start (r_start_x),
        .i_goal  (r_goal_x),
        .i_count (r_count),
        .i_total (r_total),
        .o_done  (x_done),
        .o_angle (x_angle)
    );

    taramp_lane u_lane_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (lane_go),
        .i_start (r_start_y),
        .i_goal  (r_goal_y),
        .i_count (r_count),
        .i_total (r_total),
        .o_done  (y_done),
        .o_angle (y_angle)
    );

    taramp_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (mrg_load),
        .i_ctl       (mrg_ctl),
        .i_angle_x   (x_angle),
        .i_angle_y   (y_angle),
        .o_ready     (mrg_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

>>> sv/taramp_lane.sv
`default_nettype none

module taramp_lane (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_go,
    input  wire taramp_pkg::t_angle    i_start,
    input  wire taramp_pkg::t_angle    i_goal,
    input  wire taramp_pkg::t_frame    i_count,
    input  wire taramp_pkg::t_frame    i_total,
    output logic                       o_done,
    output taramp_pkg::t_angle         o_angle
);

    typedef enum logic [1:0] {
        L_IDLE,
        L_MUL,
        L_DIV,
        L_FIN
    } t_lane_state;

    t_lane_state                              r_state;
    logic                                     r_done;
    logic                                     r_neg;
    logic [taramp_pkg::MAG_BITS-1:0]          r_mag;
    taramp_pkg::t_angle                       r_start;
    taramp_pkg::t_frame                       r_count;
    taramp_pkg::t_frame                       r_total;
    logic [taramp_pkg::PROD_BITS-1:0]         r_num;
    logic [taramp_pkg::FRAME_BITS-1:0]        r_rem;
    logic [taramp_pkg::STEP_BITS-1:0]         r_step;
    taramp_pkg::t_angle                       r_angle;

    logic [taramp_pkg::MAG_BITS-1:0]          diff;
    logic [taramp_pkg::FRAME_BITS:0]          rem_sh;
    logic                                     ge;
    logic [taramp_pkg::MAG_BITS-1:0]          start_ext;
    logic [taramp_pkg::MAG_BITS-1:0]          sum;

    assign diff = {i_goal[taramp_pkg::ANGLE_BITS-1], i_goal}
                - {i_start[taramp_pkg::ANGLE_BITS-1], i_start};

    assign rem_sh = {r_rem, r_num[taramp_pkg::PROD_BITS-1]};
    assign ge     = rem_sh >= {1'b0, r_total};

    assign start_ext = {r_start[taramp_pkg::ANGLE_BITS-1], r_start};
    assign sum = r_neg ? start_ext - r_num[taramp_pkg::MAG_BITS-1:0]
                       : start_ext + r_num[taramp_pkg::MAG_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
            r_done  <= 1'b0;
        end else begin
            case (r_state)
                L_IDLE: begin
                    if (i_go) begin
                        r_done  <= 1'b0;
                        r_neg   <= diff[taramp_pkg::MAG_BITS-1];
                        r_mag   <= diff[taramp_pkg::MAG_BITS-1] ? -diff : diff;
                        r_start <= i_start;
                        r_count <= i_count;
                        r_total <= i_total;
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_num   <= taramp_pkg::PROD_BITS'(r_mag)
                             * taramp_pkg::PROD_BITS'(r_count);
                    r_rem   <= '0;
                    r_step  <= taramp_pkg::STEP_BITS'(taramp_pkg::PROD_BITS);
                    r_state <= L_DIV;
                end
                L_DIV: begin
                    // restoring division, one quotient bit per cycle
                    r_rem  <= ge ? taramp_pkg::FRAME_BITS'(rem_sh - {1'b0, r_total})
                                 : rem_sh[taramp_pkg::FRAME_BITS-1:0];
                    r_num  <= {r_num[taramp_pkg::PROD_BITS-2:0], ge};
                    r_step <= r_step - taramp_pkg::STEP_BITS'(1);
                    if (r_step == taramp_pkg::STEP_BITS'(1)) begin
                        r_state <= L_FIN;
                    end
                end
                L_FIN: begin
                    r_angle <= (r_total == '0) ? '0 : sum[taramp_pkg::ANGLE_BITS-1:0];
                    r_done  <= 1'b1;
                    r_state <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_done  = r_done && (r_state == L_IDLE);
    assign o_angle = r_angle;

endmodule

`default_nettype wire

>>> sv/taramp_merge.sv
`default_nettype none

module taramp_merge (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_load,
    input  wire taramp_pkg::t_mrg_ctl   i_ctl,
    input  wire taramp_pkg::t_angle     i_angle_x,
    input  wire taramp_pkg::t_angle     i_angle_y,
    output logic                        o_ready,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output taramp_pkg::t_out            o_out
);

    logic              r_valid;
    taramp_pkg::t_out  r_out;
    taramp_pkg::t_out  n_out;
    logic              nonzero;

    always_comb begin
        n_out.angle_x_now = i_ctl.zero_angles ? '0 : i_angle_x;
        n_out.angle_y_now = i_ctl.zero_angles ? '0 : i_angle_y;
        nonzero           = (n_out.angle_x_now != '0) || (n_out.angle_y_now != '0);
        n_out.finished    = i_ctl.count >= i_ctl.total;
        n_out.changed     = !n_out.finished || nonzero;
        n_out.rotate      = i_ctl.rot_en && nonzero;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out <= n_out;
        end
    end

    assign o_ready     = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
